@@ rtl/core/xalu_pkg.sv @@
// Shared types and constants for the pipelined x86 integer ALU.
// Holds the opcode and flag-update codes, the width helpers and the stage records.
// No dependencies.
package xalu_pkg;

  localparam int unsigned DivSteps = 32;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_CMP   = 4'd2,
    OP_INC   = 4'd3,
    OP_DEC   = 4'd4,
    OP_NEG   = 4'd5,
    OP_ADC   = 4'd6,
    OP_SBB   = 4'd7,
    OP_MUL   = 4'd8,
    OP_IMUL1 = 4'd9,
    OP_IMUL2 = 4'd10,
    OP_IMUL3 = 4'd11,
    OP_DIV   = 4'd12,
    OP_IDIV  = 4'd13
  } op_e;

  typedef enum logic [1:0] {
    FU_NONE = 2'd0,
    FU_ALL  = 2'd1,
    FU_NOCF = 2'd2
  } fu_e;

  localparam logic [1:0] WcByte = 2'd0;
  localparam logic [1:0] WcWord = 2'd1;

  // Operand mask at the selected width (code three acts as 32 bits).
  function automatic logic [31:0] wmask(input logic [1:0] wc);
    logic [31:0] m;
    case (wc)
      WcByte:  m = 32'h0000_00ff;
      WcWord:  m = 32'h0000_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] sbit(input logic [1:0] wc);
    logic [31:0] b;
    case (wc)
      WcByte:  b = 32'h0000_0080;
      WcWord:  b = 32'h0000_8000;
      default: b = 32'h8000_0000;
    endcase
    return b;
  endfunction

  function automatic logic [5:0] wbits(input logic [1:0] wc);
    logic [5:0] n;
    case (wc)
      WcByte:  n = 6'd8;
      WcWord:  n = 6'd16;
      default: n = 6'd32;
    endcase
    return n;
  endfunction

  // Sign-extend a width-masked value to 33 bits for the shared multiplier.
  function automatic logic [32:0] sext33(input logic [31:0] v, input logic [1:0] wc);
    logic [32:0] r;
    case (wc)
      WcByte:  r = {{25{v[7]}}, v[7:0]};
      WcWord:  r = {{17{v[15]}}, v[15:0]};
      default: r = {v[31], v};
    endcase
    return r;
  endfunction

  typedef struct packed {
    op_e         op;
    logic [1:0]  wc;
    logic [31:0] dest;
    logic [31:0] src;
    logic [31:0] src2;
    logic [31:0] acc_lo;
    logic [31:0] acc_hi;
    logic        cin;
  } req_t;

  typedef struct packed {
    op_e         op;
    logic [1:0]  wc;
    logic [31:0] acc_lo;
    logic [31:0] acc_hi;
    logic [31:0] res;
    logic        dw;
    logic        zf;
    logic        sf;
    logic        cf;
    logic        of;
    fu_e         fu;
    logic [63:0] prod;
    logic [31:0] dmag;
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] lo;
    logic        nneg;
    logic        dneg;
    logic        pfault;
  } stg_t;

  typedef struct packed {
    logic        fault;
    fu_e         fu;
    logic        of;
    logic        cf;
    logic        sf;
    logic        zf;
    logic        aw;
    logic [31:0] ahr;
    logic [31:0] alr;
    logic        dw;
    logic [31:0] dres;
  } rsp_t;

endpackage

@@ rtl/core/x86_integer_alu_with_flags.sv @@
// Top level of the pipelined x86 integer ALU with flags.
// Depends on xalu_pkg.
//
// Usage:
//   One request enters on the s_axis channel, one response leaves on m_axis
//   for each request, in order. A transaction completes when tvalid and
//   tready are both high at a rising edge of clk_i.
//   From input transaction to response, every request passes through
//   an input register, an operand stage (add/sub flags, 33x33 multiplier,
//   divide operand prep), 32 restoring-divide stages of at most one
//   quotient bit each, and the output register. Every operation walks the
//   same pipe, so results stay in order. Throughput is one transaction per
//   cycle unless the receiver stalls the pipe; the divide pipe sets the depth.
//   rst_ni clears all valid bits; no response is pending after reset.
//   When the receiver holds m_axis_tready low with a response waiting, the
//   whole pipe freezes and s_axis_tready drops in the same cycle; nothing is
//   dropped or repeated, and flow resumes once the response is taken.
//   A zero divisor or an oversized quotient returns divide_fault with the
//   accumulators echoed and no write.
module x86_integer_alu_with_flags (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // lsb up: req_type[4], width_code[2], dest_value[32], src_value[32],
  // src2_value[32], acc_low[32], acc_high[32], carry_in[1], zero pad[1]
  input  logic [167:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // lsb up: dest_result[32], dest_write[1], acc_low_result[32],
  // acc_high_result[32], acc_write[1], zero_flag, sign_flag, carry_flag,
  // overflow_flag[1 each], flag_update[2], divide_fault[1], zero pad[7]
  output logic [111:0] m_axis_tdata
);
  import xalu_pkg::*;

  logic en;
  logic in_vld_q;
  req_t in_q;
  logic vld_q [0:DivSteps];
  stg_t chain_q [0:DivSteps];
  logic out_vld_q;
  rsp_t out_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_q};

  // ---------------- input register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q.op     <= op_e'(s_axis_tdata[3:0]);
      in_q.wc     <= s_axis_tdata[5:4];
      in_q.dest   <= s_axis_tdata[37:6];
      in_q.src    <= s_axis_tdata[69:38];
      in_q.src2   <= s_axis_tdata[101:70];
      in_q.acc_lo <= s_axis_tdata[133:102];
      in_q.acc_hi <= s_axis_tdata[165:134];
      in_q.cin    <= s_axis_tdata[166];
    end
  end

  // ---------------- operand stage ----------------
  logic [31:0] m, sbm, d, s, s2, x, y, r;
  logic        ci, sub, carry, ovf;
  logic [32:0] sum33;
  logic signed [32:0] ma, mb;
  logic signed [65:0] p;
  logic [63:0] n, nneg64, nm;
  logic        nneg, dneg;
  logic [31:0] dmag, hi, lo;
  fu_e         fu;
  logic        dw;
  stg_t        a_d;

  always_comb begin
    m   = wmask(in_q.wc);
    sbm = sbit(in_q.wc);
    d   = in_q.dest & m;
    s   = in_q.src & m;
    s2  = in_q.src2 & m;
    x   = d;
    y   = s;
    ci  = 1'b0;
    sub = 1'b0;
    fu  = FU_NONE;
    dw  = 1'b0;
    ma  = '0;
    mb  = '0;
    unique case (in_q.op)
      OP_ADD:  begin fu = FU_ALL; dw = 1'b1; end
      OP_SUB:  begin sub = 1'b1; fu = FU_ALL; dw = 1'b1; end
      OP_CMP:  begin sub = 1'b1; fu = FU_ALL; end
      OP_INC:  begin y = 32'd1; fu = FU_NOCF; dw = 1'b1; end
      OP_DEC:  begin y = 32'd1; sub = 1'b1; fu = FU_NOCF; dw = 1'b1; end
      OP_NEG:  begin x = '0; y = d; sub = 1'b1; fu = FU_ALL; dw = 1'b1; end
      OP_ADC:  begin ci = in_q.cin; fu = FU_ALL; dw = 1'b1; end
      OP_SBB:  begin ci = in_q.cin; sub = 1'b1; fu = FU_ALL; dw = 1'b1; end
      OP_MUL:  begin ma = {1'b0, d}; mb = {1'b0, in_q.acc_lo & m}; end
      OP_IMUL1: begin
        ma = sext33(d, in_q.wc);
        mb = sext33(in_q.acc_lo & m, in_q.wc);
      end
      OP_IMUL2: begin ma = sext33(d, in_q.wc); mb = sext33(s, in_q.wc); dw = 1'b1; end
      OP_IMUL3: begin ma = sext33(s, in_q.wc); mb = sext33(s2, in_q.wc); dw = 1'b1; end
      default: ;
    endcase

    sum33 = sub ? ({1'b0, x} - {1'b0, y} - {32'd0, ci})
                : ({1'b0, x} + {1'b0, y} + {32'd0, ci});
    r = sum33[31:0] & m;
    if (sub) begin
      carry = sum33[32];
      ovf   = |((x ^ y) & (x ^ r) & sbm);
    end else begin
      case (in_q.wc)
        WcByte:  carry = sum33[8];
        WcWord:  carry = sum33[16];
        default: carry = sum33[32];
      endcase
      ovf = |((x ^ r) & (y ^ r) & sbm);
    end

    p = ma * mb;

    // divide operands: magnitudes, high half as starting remainder,
    // low half left-aligned so each active divide stage consumes its msb
    case (in_q.wc)
      WcByte:  n = {48'd0, in_q.acc_lo[15:0]};
      WcWord:  n = {32'd0, in_q.acc_hi[15:0], in_q.acc_lo[15:0]};
      default: n = {in_q.acc_hi, in_q.acc_lo};
    endcase
    case (in_q.wc)
      WcByte:  nneg = n[15];
      WcWord:  nneg = n[31];
      default: nneg = n[63];
    endcase
    nneg   = nneg && (in_q.op == OP_IDIV);
    dneg   = (|(d & sbm)) && (in_q.op == OP_IDIV);
    nneg64 = ~n + 64'd1;
    nm     = nneg ? nneg64 : n;
    dmag   = dneg ? ((~d + 32'd1) & m) : d;
    case (in_q.wc)
      WcByte:  begin hi = {24'd0, nm[15:8]};  lo = {nm[7:0], 24'd0}; end
      WcWord:  begin hi = {16'd0, nm[31:16]}; lo = {nm[15:0], 16'd0}; end
      default: begin hi = nm[63:32];          lo = nm[31:0]; end
    endcase

    a_d.op     = in_q.op;
    a_d.wc     = in_q.wc;
    a_d.acc_lo = in_q.acc_lo;
    a_d.acc_hi = in_q.acc_hi;
    a_d.res    = (fu != FU_NONE) ? r : '0;
    a_d.dw     = dw;
    a_d.zf     = (fu != FU_NONE) && (r == '0);
    a_d.sf     = (fu != FU_NONE) && (|(r & sbm));
    a_d.cf     = (fu == FU_ALL) && carry;
    a_d.of     = (fu != FU_NONE) && ovf;
    a_d.fu     = fu;
    a_d.prod   = p[63:0];
    a_d.dmag   = dmag;
    a_d.rem    = hi;
    a_d.quo    = '0;
    a_d.lo     = lo;
    a_d.nneg   = nneg;
    a_d.dneg   = dneg;
    // quotient fits the width only if the high half is below the divisor
    a_d.pfault = (d == '0) || (hi >= dmag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      chain_q[0] <= a_d;
    end
  end

  // ---------------- restoring divide, at most one quotient bit per stage ----------------
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    stg_t        nxt;
    logic        act;
    logic [32:0] t, diff;

    always_comb begin
      nxt  = chain_q[k];
      // narrow widths skip the leading stages
      act  = 6'(k) >= (6'd32 - wbits(chain_q[k].wc));
      t    = {chain_q[k].rem, chain_q[k].lo[31]};
      diff = t - {1'b0, chain_q[k].dmag};
      if (act) begin
        nxt.lo = {chain_q[k].lo[30:0], 1'b0};
        if (!diff[32]) begin
          nxt.rem = diff[31:0];
          nxt.quo = {chain_q[k].quo[30:0], 1'b1};
        end else begin
          nxt.rem = t[31:0];
          nxt.quo = {chain_q[k].quo[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        chain_q[k+1] <= nxt;
      end
    end
  end

  // ---------------- result assembly ----------------
  stg_t        c;
  logic [31:0] fm, fsb, qv, rv;
  logic        is_div, qneg, sover, fault;
  rsp_t        o_d;

  always_comb begin
    c      = chain_q[DivSteps];
    fm     = wmask(c.wc);
    fsb    = sbit(c.wc);
    is_div = (c.op == OP_DIV) || (c.op == OP_IDIV);
    qneg   = c.nneg ^ c.dneg;
    sover  = qneg ? (c.quo > fsb) : (c.quo > (fsb - 32'd1));
    fault  = is_div && (c.pfault || ((c.op == OP_IDIV) && sover));
    qv     = qneg ? ((~c.quo + 32'd1) & fm) : c.quo;
    rv     = c.nneg ? ((~c.rem + 32'd1) & fm) : c.rem;

    o_d.fault = fault;
    o_d.fu    = c.fu;
    o_d.of    = c.of;
    o_d.cf    = c.cf;
    o_d.sf    = c.sf;
    o_d.zf    = c.zf;
    o_d.aw    = 1'b0;
    o_d.alr   = c.acc_lo;
    o_d.ahr   = c.acc_hi;
    o_d.dw    = c.dw;
    o_d.dres  = c.res;

    unique case (c.op)
      OP_MUL, OP_IMUL1: begin
        o_d.aw = 1'b1;
        case (c.wc)
          WcByte: o_d.alr = {c.acc_lo[31:16], c.prod[15:0]};
          WcWord: begin
            o_d.alr = {c.acc_lo[31:16], c.prod[15:0]};
            o_d.ahr = {c.acc_hi[31:16], c.prod[31:16]};
          end
          default: begin
            o_d.alr = c.prod[31:0];
            o_d.ahr = c.prod[63:32];
          end
        endcase
      end
      OP_IMUL2, OP_IMUL3: o_d.dres = c.prod[31:0] & fm;
      OP_DIV, OP_IDIV: begin
        if (!fault) begin
          o_d.aw = 1'b1;
          case (c.wc)
            WcByte: o_d.alr = {c.acc_lo[31:16], rv[7:0], qv[7:0]};
            WcWord: begin
              o_d.alr = {c.acc_lo[31:16], qv[15:0]};
              o_d.ahr = {c.acc_hi[31:16], rv[15:0]};
            end
            default: begin
              o_d.alr = qv;
              o_d.ahr = rv;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= o_d;
    end
  end

`ifndef ASSERT_OFF
  // a faulting divide writes nothing and leaves the flags undefined
  a_fault_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.fault) |-> (!out_q.aw && !out_q.dw && out_q.fu == FU_NONE))
    else $error("divide fault with a write");

  // undefined flags always read as zero
  a_flags_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.fu == FU_NONE) |-> !(out_q.zf || out_q.sf || out_q.cf || out_q.of))
    else $error("flags set while not updated");

  // destination and accumulator writes are exclusive
  a_one_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.dw && out_q.aw))
    else $error("both destination and accumulator written");

  // a frozen pipe keeps the valid bit of the last divide stage unchanged
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q[DivSteps]))
    else $error("pipe advanced during stall");
`endif

endmodule

@@ verif/x86_integer_alu_with_flags_test.sv @@
// Self-checking bench for the x86 integer ALU with flags.
// Drives requests on s_axis, predicts each response and compares it on m_axis.
// Depends on xalu_pkg and x86_integer_alu_with_flags.
module x86_integer_alu_with_flags_test;
  timeunit 1ns;
  timeprecision 1ps;

  import xalu_pkg::*;

  typedef struct {
    logic [3:0]  op;
    logic [1:0]  wc;
    logic [31:0] dst;
    logic [31:0] src;
    logic [31:0] src2;
    logic [31:0] alo;
    logic [31:0] ahi;
    logic        cin;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] dres;
    logic        dw;
    logic [31:0] alr;
    logic [31:0] ahr;
    logic        aw;
    logic        zf;
    logic        sf;
    logic        cf;
    logic        of;
    logic [1:0]  fu;
    logic        fault;
  } alu_rsp_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;

  x86_integer_alu_with_flags dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #2 clk_i = ~clk_i;

  alu_rsp_t    pending_q[$];
  int          errors = 0;
  int          n_sent = 0;
  int          n_got = 0;
  int          n_fault = 0;
  bit          long_hold = 1'b0;
  bit          stim_done = 1'b0;

  function automatic logic [63:0] sx(logic [31:0] v, logic [1:0] wc);
    case (wc)
      WcByte:  sx = {{56{v[7]}}, v[7:0]};
      WcWord:  sx = {{48{v[15]}}, v[15:0]};
      default: sx = {{32{v[31]}}, v};
    endcase
  endfunction

  // Behavioral model of one ALU operation.
  function automatic alu_rsp_t alu_predict(alu_req_t q);
    alu_rsp_t    o;
    int unsigned w;
    logic [63:0] m, sb, d, s, s2, t, r, p, n, n2m, nm, dm, qq, rm, qv, rv;
    logic        nneg, dneg, qneg;
    w  = (q.wc == WcByte) ? 8 : (q.wc == WcWord) ? 16 : 32;
    m  = (64'd1 << w) - 1;
    sb = 64'd1 << (w - 1);
    d = q.dst & m; s = q.src & m; s2 = q.src2 & m;
    r = 0;
    o = '{default: '0};
    o.alr = q.alo; o.ahr = q.ahi;
    case (q.op)
      OP_ADD, OP_ADC: begin
        t = d + s + ((q.op == OP_ADC) ? q.cin : 1'b0); r = t & m;
        o.cf = t[w];
        o.of = (((d ^ r) & (s ^ r) & sb) != 0);
        o.dw = 1; o.fu = FU_ALL;
      end
      OP_SUB, OP_CMP, OP_SBB: begin
        t = (q.op == OP_SBB) ? s + q.cin : s;
        r = (d - t) & m;
        o.cf = d < t;
        o.of = (((d ^ s) & (d ^ r) & sb) != 0);
        o.dw = (q.op != OP_CMP); o.fu = FU_ALL;
      end
      OP_INC: begin
        r = (d + 1) & m; o.of = (r == sb); o.dw = 1; o.fu = FU_NOCF;
      end
      OP_DEC: begin
        r = (d - 1) & m; o.of = (r == sb - 1); o.dw = 1; o.fu = FU_NOCF;
      end
      OP_NEG: begin
        r = (0 - d) & m; o.cf = (d != 0); o.of = (d == sb); o.dw = 1; o.fu = FU_ALL;
      end
      OP_MUL, OP_IMUL1: begin
        p = (q.op == OP_MUL) ? d * (q.alo & m) : sx(d, q.wc) * sx(q.alo & m, q.wc);
        if (w == 8) o.alr = {q.alo[31:16], p[15:0]};
        else if (w == 16) begin
          o.alr = {q.alo[31:16], p[15:0]};
          o.ahr = {q.ahi[31:16], p[31:16]};
        end else begin
          o.alr = p[31:0]; o.ahr = p[63:32];
        end
        o.aw = 1;
      end
      OP_IMUL2: begin r = (sx(d, q.wc) * sx(s, q.wc)) & m; o.dw = 1; end
      OP_IMUL3: begin r = (sx(s, q.wc) * sx(s2, q.wc)) & m; o.dw = 1; end
      OP_DIV, OP_IDIV: begin
        n2m = (w == 32) ? 64'hffff_ffff_ffff_ffff : (64'd1 << (2 * w)) - 1;
        n = (w == 8) ? {48'd0, q.alo[15:0]} : (((q.ahi & m) << w) | (q.alo & m)) & n2m;
        qv = 0; rv = 0;
        if (d == 0) o.fault = 1;
        else if (q.op == OP_DIV) begin
          qq = n / d; rm = n % d;
          if (qq > m) o.fault = 1;
          else begin qv = qq; rv = rm; end
        end else begin
          nneg = n[2 * w - 1]; dneg = d[w - 1];
          nm = nneg ? ((0 - n) & n2m) : n;
          dm = dneg ? ((0 - d) & m) : d;
          qq = nm / dm; rm = nm % dm;
          qneg = nneg != dneg;
          if (qneg ? (qq > sb) : (qq > sb - 1)) o.fault = 1;
          else begin
            qv = qneg ? ((0 - qq) & m) : qq;
            rv = nneg ? ((0 - rm) & m) : rm;
          end
        end
        if (!o.fault) begin
          if (w == 8) o.alr = {q.alo[31:16], rv[7:0], qv[7:0]};
          else if (w == 16) begin
            o.alr = {q.alo[31:16], qv[15:0]};
            o.ahr = {q.ahi[31:16], rv[15:0]};
          end else begin
            o.alr = qv[31:0]; o.ahr = rv[31:0];
          end
          o.aw = 1;
        end
      end
      default: ;
    endcase
    if (o.fu != FU_NONE) begin
      o.zf = (r == 0);
      o.sf = ((r & sb) != 0);
      if (o.fu == FU_NOCF) o.cf = 0;
    end else begin
      o.cf = 0; o.of = 0;
    end
    o.dres = r[31:0];
    return o;
  endfunction

  function automatic logic [167:0] pack_req(alu_req_t q);
    return {1'b0, q.cin, q.ahi, q.alo, q.src2, q.src, q.dst, q.wc, q.op};
  endfunction

  function automatic alu_rsp_t unpack_rsp(logic [111:0] v);
    alu_rsp_t o;
    o.dres = v[31:0];   o.dw = v[32];
    o.alr = v[64:33];   o.ahr = v[96:65];
    o.aw = v[97];       o.zf = v[98];  o.sf = v[99];
    o.cf = v[100];      o.of = v[101]; o.fu = v[103:102];
    o.fault = v[104];
    return o;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return {24'h0, $urandom_range(126, 129)} << (8 * $urandom_range(0, 3));
      3: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  function automatic alu_req_t rand_req();
    alu_req_t q;
    q.op = $urandom_range(0, 15) < 14 ? $urandom_range(0, 13) : $urandom_range(14, 15);
    q.wc = ($urandom_range(0, 15) == 0) ? 2'd3 : $urandom_range(0, 2);
    q.dst = rand_operand(); q.src = rand_operand(); q.src2 = rand_operand();
    q.alo = rand_operand(); q.ahi = rand_operand(); q.cin = $urandom_range(0, 1);
    // keep divides mostly in range so quotients come back
    if ((q.op == OP_DIV || q.op == OP_IDIV) && $urandom_range(0, 3) != 0) begin
      if ($urandom_range(0, 1)) q.ahi = 32'h0;
      else q.ahi = {32{q.alo[31]}};
      if (q.wc == WcByte) q.alo[15:8] = {8{q.alo[7]}} & {8{q.ahi[0]}};
      if (q.dst == 0) q.dst = $urandom | 1;
    end
    return q;
  endfunction

  // one transaction offered and held until taken
  task automatic send_req(alu_req_t q);
    s_axis_tdata <= pack_req(q);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_q.push_back(alu_predict(q));
    n_sent++;
  endtask

  // directed stimulus; has_exp rows carry a typed-in response
  typedef struct {
    alu_req_t q;
    bit       has_exp;
    alu_rsp_t e;
  } dir_row_t;

  dir_row_t dir_tbl[$];

  task automatic add_row(logic [3:0] op, logic [1:0] wc, logic [31:0] d, logic [31:0] s,
                         logic [31:0] s2, logic [31:0] al, logic [31:0] ah, logic c);
    dir_row_t rw;
    rw.q = '{op, wc, d, s, s2, al, ah, c};
    rw.has_exp = 1'b0;
    rw.e = alu_predict(rw.q);
    dir_tbl.push_back(rw);
  endtask

  initial begin
    dir_row_t rw;
    int       burst;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(OP_ADD, WcByte, 32'hff, 32'h01, 0, 0, 0, 0);
    add_row(OP_ADD, 2'd2, 32'h7fff_ffff, 32'h1, 0, 0, 0, 0);
    add_row(OP_SUB, WcWord, 32'h0, 32'h1, 0, 0, 0, 0);
    add_row(OP_CMP, 2'd2, 32'h8000_0000, 32'h1, 0, 0, 0, 0);
    add_row(OP_INC, WcByte, 32'h7f, 0, 0, 0, 0, 1);
    add_row(OP_DEC, WcWord, 32'h8000, 0, 0, 0, 0, 1);
    add_row(OP_NEG, 2'd2, 32'h8000_0000, 0, 0, 0, 0, 0);
    add_row(OP_NEG, WcByte, 32'h0, 0, 0, 0, 0, 0);
    add_row(OP_ADC, WcWord, 32'hffff, 32'h0, 0, 0, 0, 1);
    add_row(OP_SBB, 2'd2, 32'h0, 32'hffff_ffff, 0, 0, 0, 1);
    add_row(OP_MUL, 2'd2, 32'hffff_ffff, 0, 0, 32'hffff_ffff, 32'h1234_5678, 0);
    add_row(OP_IMUL1, WcByte, 32'h80, 0, 0, 32'hdead_be80, 32'hffff_ffff, 0);
    add_row(OP_IMUL1, WcWord, 32'h8000, 0, 0, 32'hffff_7fff, 32'hffff_ffff, 0);
    add_row(OP_IMUL2, 2'd2, 32'h8000_0000, 32'hffff_ffff, 0, 0, 0, 0);
    add_row(OP_IMUL3, WcWord, 32'hffff_ffff, 32'h7fff, 32'h8000, 0, 0, 0);
    add_row(OP_DIV, 2'd2, 32'h7, 0, 0, 32'd100, 32'd0, 0);
    add_row(OP_IDIV, WcByte, 32'hf9, 0, 0, 32'h0000_ff9c, 0, 0);
    add_row(OP_IDIV, WcWord, 32'hffff, 0, 0, 32'h0000_0000, 32'h0000_8000, 0);
    add_row(OP_ADD, 2'd3, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0, 0);
    // divide by zero: fault, accumulators echoed, nothing written
    rw.q = '{OP_DIV, WcWord, 32'h0, 32'h0, 32'h0, 32'h1111_2222, 32'h3333_4444, 1'b0};
    rw.has_exp = 1'b1;
    rw.e = '{32'h0, 1'b0, 32'h1111_2222, 32'h3333_4444, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
             FU_NONE, 1'b1};
    dir_tbl.push_back(rw);
    // quotient too wide: fault
    rw.q = '{OP_DIV, WcByte, 32'h1, 32'h0, 32'h0, 32'h0000_0100, 32'h0, 1'b0};
    rw.e = '{32'h0, 1'b0, 32'h0000_0100, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FU_NONE, 1'b1};
    dir_tbl.push_back(rw);
    // unused request code: nothing written, accumulators echoed
    rw.q = '{4'd15, 2'd2, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hcafe_f00d,
             32'h0bad_beef, 1'b1};
    rw.e = '{32'h0, 1'b0, 32'hcafe_f00d, 32'h0bad_beef, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
             FU_NONE, 1'b0};
    dir_tbl.push_back(rw);
    rw.q.op = 4'd14;
    dir_tbl.push_back(rw);

    foreach (dir_tbl[i]) begin
      send_req(dir_tbl[i].q);
      if (dir_tbl[i].has_exp) pending_q[$] = dir_tbl[i].e;
    end
    s_axis_tvalid <= 1'b0;

    // let the pipe drain completely before the random part
    while (pending_q.size() != 0) @(posedge clk_i);

    long_hold = 1'b1;
    while (n_sent < 1900) begin
      burst = $urandom_range(1, 40);
      repeat (burst) send_req(rand_req());
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: random stall pattern plus one long hold while the sender keeps going
  initial begin
    int hold;
    while (!rst_ni) @(posedge clk_i);
    while (!long_hold) begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
      @(posedge clk_i);
    end
    repeat (30) begin
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
    m_axis_tready <= 1'b0;
    for (hold = 0; hold < 120; hold++) @(posedge clk_i);
    forever begin
      case ($urandom_range(0, 3))
        0: m_axis_tready <= 1'b0;
        1: m_axis_tready <= ($urandom_range(0, 7) != 0);
        default: m_axis_tready <= 1'b1;
      endcase
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // response checker
  always @(posedge clk_i) begin
    alu_rsp_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = unpack_rsp(m_axis_tdata);
      n_got++;
      if (got.fault) n_fault++;
      if (pending_q.size() == 0) begin
        $display("%0t: response with nothing pending: %h", $realtime, m_axis_tdata);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          $display("%0t: response %0d mismatch", $realtime, n_got);
          $display("  exp dres=%h dw=%b alr=%h ahr=%h aw=%b z=%b s=%b c=%b o=%b fu=%0d f=%b",
                   want.dres, want.dw, want.alr, want.ahr, want.aw, want.zf, want.sf,
                   want.cf, want.of, want.fu, want.fault);
          $display("  got dres=%h dw=%b alr=%h ahr=%h aw=%b z=%b s=%b c=%b o=%b fu=%0d f=%b",
                   got.dres, got.dw, got.alr, got.ahr, got.aw, got.zf, got.sf,
                   got.cf, got.of, got.fu, got.fault);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("Sent %0d requests, checked %0d responses (%0d divide faults),",
             n_sent, n_got, n_fault);
    $display("all opcodes and widths with random stalls on both sides.");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout with %0d responses pending", pending_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/xalu_pkg.sv
rtl/core/x86_integer_alu_with_flags.sv
verif/x86_integer_alu_with_flags_test.sv
